// ----- hw/rtl/rle24_pkg.sv -----
// ----------------------------------------------------------------------------
// rle24_pkg
// Shared types and constants of the 24-bit run-length row packet encoder.
// ----------------------------------------------------------------------------
package rle24_pkg;

    // longest raw stretch, range 1 to 127
    localparam logic [7:0] RLE_MAX_RAW = 8'd127;
    localparam logic [7:0] RLE_RUN_CAP = 8'd128;

    localparam int RAW_AW    = 7;
    localparam int RAW_DEPTH = 2 ** RAW_AW;

    localparam logic [7:0] HDR_RUN    = 8'h80;
    localparam logic [7:0] HDR_SINGLE = 8'h00;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_PEND,
        MODE_RUN,
        MODE_RAW
    } t_mode;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_RHDR,
        SQ_RRD,
        SQ_RPX,
        SQ_P1,
        SQ_P2
    } t_seq_state;

    // one stream byte from the sequencer to the word packer
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_byte_beat;

endpackage

// ----- hw/rtl/rle24_word_pack.sv -----
// ----------------------------------------------------------------------------
// rle24_word_pack
// Gathers stream bytes into 8-byte words and holds each word in an output
// register until the master side takes it.
// ----------------------------------------------------------------------------
module rle24_word_pack (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rle24_pkg::t_byte_beat i_beat,
    output logic                  o_beat_ready,
    // fields from bit 0 up: out_bytes[63:0], byte_count[67:64], zero pad
    output logic [71:0]           m_axis_tdata,
    output logic                  m_axis_tvalid,
    output logic                  m_axis_tlast,
    input  logic                  m_axis_tready
);
    import rle24_pkg::*;

    logic [63:0] r_acc;
    logic [2:0]  r_cnt;
    logic [63:0] r_word;
    logic [3:0]  r_bcnt;
    logic        r_last;
    logic        r_valid;

    logic [63:0] merged;
    logic        completes;
    logic        out_free;
    logic        accept;

    assign completes    = i_beat.last || (r_cnt == 3'd7);
    assign out_free     = !r_valid || m_axis_tready;
    assign o_beat_ready = !completes || out_free;
    assign accept       = i_beat.valid && o_beat_ready;

    always_comb begin
        merged = r_acc;
        merged[{r_cnt, 3'b000} +: 8] = i_beat.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= 3'd0;
            r_acc   <= 64'd0;
        end else begin
            if (accept && completes) begin
                r_word  <= merged;
                r_bcnt  <= {1'b0, r_cnt} + 4'd1;
                r_last  <= i_beat.last;
                r_valid <= 1'b1;
                // clear so short words carry zero high bytes
                r_acc   <= 64'd0;
                r_cnt   <= 3'd0;
            end else begin
                if (r_valid && m_axis_tready) begin
                    r_valid <= 1'b0;
                end
                if (accept) begin
                    r_acc <= merged;
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    assign m_axis_tdata  = {4'd0, r_bcnt, r_word};
    assign m_axis_tvalid = r_valid;
    assign m_axis_tlast  = r_last;

endmodule

// ----- hw/rtl/rle24_row_packet_encoder_top.sv -----
// ----------------------------------------------------------------------------
// rle24_row_packet_encoder_top
// Run-length packet encoder for 24-bit pixels, one row at a time.
// ----------------------------------------------------------------------------
// A pixel beat is decided in the cycle it is accepted. A pixel that closes no
// packet leaves the block ready again in the next cycle. A pixel that closes
// packets then holds s_axis_tready low while a byte-serial sequencer feeds the
// shared word packer one byte per cycle whenever the packer is ready, apart
// from raw buffer reads: a run or single packet is four bytes, and a raw flush
// of n pixels is one header byte, then per pixel one read of the raw buffer's
// single port and three pixel bytes. The master side can stall the output
// register. The raw buffer needs no clearing after reset; only entries
// written in the current stretch are read.
// ----------------------------------------------------------------------------
module rle24_row_packet_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    // fields from bit 0 up: pixel[31:0]
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // fields from bit 0 up: out_bytes[63:0], byte_count[67:64], zero pad
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    output logic        m_axis_tlast,
    input  logic        m_axis_tready
);
    import rle24_pkg::*;

    logic [15:0] r_row_width;
    logic [15:0] r_col;
    logic [31:0] r_held;
    t_mode       r_mode;
    logic [7:0]  r_pc;

    logic [23:0] r_raw_mem [RAW_DEPTH];
    logic [23:0] r_rdata;

    // packets queued by the last decision
    logic        r_flush;
    logic [7:0]  r_fn;
    logic        r_p1;
    logic [31:0] r_p1_bytes;
    logic        r_p2;
    logic [31:0] r_p2_bytes;

    t_seq_state  r_seq, n_seq;
    logic [1:0]  r_bi, n_bi;
    logic [7:0]  r_idx, n_idx;
    logic        rd_en;

    t_byte_beat  beat;
    logic        beat_ready;
    logic        beat_acc;

    logic        in_acc;
    logic [31:0] p;
    logic        row_last;
    logic        eq;

    // decision results
    t_mode       d_mode;
    logic [31:0] d_held;
    logic [7:0]  d_pc;
    logic        d_flush;
    logic [7:0]  d_fn;
    logic        d_p1;
    logic [7:0]  d_p1_hdr;
    logic [23:0] d_p1_px;
    logic        d_p2;
    logic        d_wr;
    logic [RAW_AW-1:0] d_wr_addr;
    logic        raw_join;
    logic [7:0]  raw_c;
    logic [7:0]  run_c;
    logic [7:0]  run_m1;

    assign p             = s_axis_tdata;
    assign s_axis_tready = (r_seq == SQ_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign eq            = (p == r_held);
    assign row_last      = (r_row_width <= 16'd1) ||
                           (({1'b0, r_col} + 17'd1) >= {1'b0, r_row_width});

    always_comb begin
        d_mode    = r_mode;
        d_held    = r_held;
        d_pc      = r_pc;
        d_flush   = 1'b0;
        d_fn      = 8'd0;
        d_p1      = 1'b0;
        d_p1_hdr  = HDR_SINGLE;
        d_p1_px   = p[23:0];
        d_p2      = 1'b0;
        d_wr      = 1'b0;
        d_wr_addr = r_pc[RAW_AW-1:0];
        raw_join  = 1'b0;
        raw_c     = r_pc + 8'd1;
        run_c     = r_pc + 8'd1;
        run_m1    = 8'd0;
        case (r_mode)
            MODE_IDLE: begin
                if (row_last) begin
                    d_p1 = 1'b1;
                end else begin
                    d_held = p;
                    d_mode = MODE_PEND;
                end
            end
            MODE_PEND, MODE_RAW: begin
                if (!eq) begin
                    raw_join = 1'b1;
                    d_wr     = 1'b1;
                    if (r_mode == MODE_PEND) begin
                        d_wr_addr = '0;
                        raw_c     = 8'd1;
                    end
                end else begin
                    if (r_mode == MODE_RAW) begin
                        d_flush = 1'b1;
                        d_fn    = r_pc;
                    end
                    if (row_last) begin
                        d_p1     = 1'b1;
                        d_p1_hdr = HDR_RUN | 8'd1;
                        d_p1_px  = r_held[23:0];
                        d_pc     = 8'd0;
                        d_mode   = MODE_IDLE;
                    end else begin
                        d_pc   = 8'd2;
                        d_mode = MODE_RUN;
                    end
                end
            end
            MODE_RUN: begin
                d_p1_px = r_held[23:0];
                if (eq) begin
                    if (row_last || (run_c >= RLE_RUN_CAP)) begin
                        run_m1 = run_c - 8'd1;
                        d_p1   = 1'b1;
                        d_pc   = 8'd0;
                        d_mode = MODE_IDLE;
                    end else begin
                        d_pc = run_c;
                    end
                end else begin
                    run_m1 = r_pc - 8'd1;
                    d_p1   = 1'b1;
                    d_pc   = 8'd0;
                    if (row_last) begin
                        d_p2   = 1'b1;
                        d_mode = MODE_IDLE;
                    end else begin
                        d_held = p;
                        d_mode = MODE_PEND;
                    end
                end
                d_p1_hdr = HDR_RUN | {1'b0, run_m1[6:0]};
            end
            default: begin
                d_mode = MODE_IDLE;
            end
        endcase

        // held pixel joined the raw stretch
        if (raw_join) begin
            if (row_last) begin
                d_flush = 1'b1;
                d_fn    = raw_c;
                d_p1    = 1'b1;
                d_pc    = 8'd0;
                d_mode  = MODE_IDLE;
            end else if (raw_c >= RLE_MAX_RAW) begin
                d_flush = 1'b1;
                d_fn    = raw_c;
                d_pc    = 8'd0;
                d_held  = p;
                d_mode  = MODE_PEND;
            end else begin
                d_pc   = raw_c;
                d_held = p;
                d_mode = MODE_RAW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= 16'd1;
            r_col       <= 16'd0;
            r_held      <= 32'd0;
            r_mode      <= MODE_IDLE;
            r_pc        <= 8'd0;
            r_flush     <= 1'b0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_row_width <= i_cfg_wr_data;
            end
            if (in_acc) begin
                r_col      <= row_last ? 16'd0 : r_col + 16'd1;
                r_held     <= d_held;
                r_mode     <= d_mode;
                r_pc       <= d_pc;
                r_flush    <= d_flush;
                r_fn       <= d_fn;
                r_p1       <= d_p1;
                r_p1_bytes <= {d_p1_px, d_p1_hdr};
                r_p2       <= d_p2;
                r_p2_bytes <= {p[23:0], HDR_SINGLE};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && d_wr) begin
            r_raw_mem[d_wr_addr] <= r_held[23:0];
        end
        if (rd_en) begin
            r_rdata <= r_raw_mem[r_idx[RAW_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= SQ_IDLE;
            r_bi  <= 2'd0;
            r_idx <= 8'd0;
        end else begin
            r_seq <= n_seq;
            r_bi  <= n_bi;
            r_idx <= n_idx;
        end
    end

    assign beat_acc = beat.valid && beat_ready;

    always_comb begin
        n_seq      = r_seq;
        n_bi       = r_bi;
        n_idx      = r_idx;
        rd_en      = 1'b0;
        beat.valid = 1'b0;
        beat.data  = 8'd0;
        beat.last  = 1'b0;
        case (r_seq)
            SQ_IDLE: begin
                n_bi  = 2'd0;
                n_idx = 8'd0;
                if (in_acc) begin
                    if (d_flush) begin
                        n_seq = SQ_RHDR;
                    end else if (d_p1) begin
                        n_seq = SQ_P1;
                    end else if (d_p2) begin
                        n_seq = SQ_P2;
                    end
                end
            end
            SQ_RHDR: begin
                beat.valid = 1'b1;
                beat.data  = r_fn - 8'd1;
                if (beat_acc) begin
                    n_seq = SQ_RRD;
                end
            end
            SQ_RRD: begin
                rd_en = 1'b1;
                n_bi  = 2'd0;
                n_seq = SQ_RPX;
            end
            SQ_RPX: begin
                beat.valid = 1'b1;
                beat.data  = r_rdata[{r_bi, 3'b000} +: 8];
                beat.last  = (r_bi == 2'd2) && ((r_idx + 8'd1) == r_fn) && !r_p1 && !r_p2;
                if (beat_acc) begin
                    if (r_bi == 2'd2) begin
                        n_bi = 2'd0;
                        if ((r_idx + 8'd1) == r_fn) begin
                            n_seq = r_p1 ? SQ_P1 : (r_p2 ? SQ_P2 : SQ_IDLE);
                        end else begin
                            n_idx = r_idx + 8'd1;
                            n_seq = SQ_RRD;
                        end
                    end else begin
                        n_bi = r_bi + 2'd1;
                    end
                end
            end
            SQ_P1: begin
                beat.valid = 1'b1;
                beat.data  = r_p1_bytes[{r_bi, 3'b000} +: 8];
                beat.last  = (r_bi == 2'd3) && !r_p2;
                if (beat_acc) begin
                    n_bi = r_bi + 2'd1;
                    if (r_bi == 2'd3) begin
                        n_seq = r_p2 ? SQ_P2 : SQ_IDLE;
                    end
                end
            end
            SQ_P2: begin
                beat.valid = 1'b1;
                beat.data  = r_p2_bytes[{r_bi, 3'b000} +: 8];
                beat.last  = (r_bi == 2'd3);
                if (beat_acc) begin
                    n_bi = r_bi + 2'd1;
                    if (r_bi == 2'd3) begin
                        n_seq = SQ_IDLE;
                    end
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    rle24_word_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_beat        (beat),
        .o_beat_ready  (beat_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tready (m_axis_tready)
    );

endmodule

// ----- hw/rtl/rle24_checker.sv -----
// ----------------------------------------------------------------------------
// rle24_checker
// Port-level checks of the row packet encoder's output words.
// ----------------------------------------------------------------------------
module rle24_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tlast,
    input logic        m_axis_tready
);

    // hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[67:64] != 4'd0) && (m_axis_tdata[67:64] <= 4'd8))
        else $error("byte count out of range");

    a_full_unless_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[67:64] == 4'd8)
        else $error("short word without last flag");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[67:64] != 4'd8) |-> m_axis_tdata[63:56] == 8'd0)
        else $error("unused high byte not zero");

endmodule

bind rle24_row_packet_encoder_top rle24_checker u_rle24_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tready (m_axis_tready)
);
